[sv/csm_pkg.sv]
// Shared types, character constants and character-class functions for the CSS minifier.
`timescale 1ns / 1ps

package csm_pkg;

    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_input;
    } csm_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       done_res;
    } csm_out_t;

    // Context that the decision on the pending byte looks at.
    typedef struct packed {
        logic [7:0] pend_byte;
        logic [7:0] prev_byte;
        logic       in_block;
        logic       in_quotes;
        logic [7:0] next_byte;
        logic       next_none;
    } csm_ctx_t;

    typedef struct packed {
        logic keep;
        logic in_block;
        logic in_quotes;
    } csm_verdict_t;

    function automatic logic is_alpha(input logic [7:0] ch);
        return ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= 8'h30) && (ch <= 8'h39);
    endfunction

    function automatic logic is_punct(input logic [7:0] ch);
        return ((ch >= 8'h21) && (ch <= 8'h2F)) || ((ch >= 8'h3A) && (ch <= 8'h40)) ||
               ((ch >= 8'h5B) && (ch <= 8'h60)) || ((ch >= 8'h7B) && (ch <= 8'h7E));
    endfunction

endpackage

[sv/css_stream_minifier_core.sv]
// Top level of the CSS stream minifier: text state registers, decision logic and result stage.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------
//  input   | src_valid | src_stall | src_item  (in_char, end_of_input)
//  result  | dst_valid | dst_stall | dst_item  (out_char, char_valid, done_res)
//
// One item is taken every cycle unless src_stall is high; its result, if any, appears in the next cycle.
// The decision on the pending byte is combinational compare logic on three bytes
// and three flags, between the text state registers and the result register.
// src_stall is high only while a result sits in the result register and is stalled.
// Reset (rst_n low) clears the text state and empties the result register.
`timescale 1ns / 1ps

module css_stream_minifier_core
    import csm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  csm_in_t  src_item,
    output logic     dst_valid,
    input  logic     dst_stall,
    output csm_out_t dst_item
);

    logic [7:0]   pend_byte_reg;
    logic [7:0]   pend_byte_next;
    logic         pend_valid_reg;
    logic         pend_valid_next;
    logic [7:0]   prev_byte_reg;
    logic [7:0]   prev_byte_next;
    logic         in_block_reg;
    logic         in_block_next;
    logic         in_quotes_reg;
    logic         in_quotes_next;

    logic         stage_ready;
    logic         accept;
    logic         kept;
    logic         emit;
    csm_ctx_t     ctx;
    csm_verdict_t verdict;
    csm_out_t     res;

    assign src_stall = !stage_ready;
    assign accept    = src_valid && stage_ready;

    assign ctx.pend_byte = pend_byte_reg;
    assign ctx.prev_byte = prev_byte_reg;
    assign ctx.in_block  = in_block_reg;
    assign ctx.in_quotes = in_quotes_reg;
    assign ctx.next_byte = src_item.in_char;
    assign ctx.next_none = src_item.end_of_input;

    csm_settle u_settle (
        .ctx     (ctx),
        .verdict (verdict)
    );

    assign kept = pend_valid_reg && verdict.keep;
    // An end item always answers; a byte item answers only when a byte is kept.
    assign emit = accept && (kept || src_item.end_of_input);

    assign res.out_char   = kept ? pend_byte_reg : 8'h00;
    assign res.char_valid = kept;
    assign res.done_res   = src_item.end_of_input;

    always_comb
    begin
        pend_byte_next  = pend_byte_reg;
        pend_valid_next = pend_valid_reg;
        prev_byte_next  = prev_byte_reg;
        in_block_next   = in_block_reg;
        in_quotes_next  = in_quotes_reg;
        if (accept)
        begin
            if (src_item.end_of_input)
            begin
                pend_byte_next  = 8'h00;
                pend_valid_next = 1'b0;
                prev_byte_next  = 8'h00;
                in_block_next   = 1'b0;
                in_quotes_next  = 1'b0;
            end
            else
            begin
                pend_byte_next  = src_item.in_char;
                pend_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    // A dropped byte still becomes the previous byte.
                    prev_byte_next = pend_byte_reg;
                    in_block_next  = verdict.in_block;
                    in_quotes_next = verdict.in_quotes;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_byte_reg  <= 8'h00;
            pend_valid_reg <= 1'b0;
            prev_byte_reg  <= 8'h00;
            in_block_reg   <= 1'b0;
            in_quotes_reg  <= 1'b0;
        end
        else
        begin
            pend_byte_reg  <= pend_byte_next;
            pend_valid_reg <= pend_valid_next;
            prev_byte_reg  <= prev_byte_next;
            in_block_reg   <= in_block_next;
            in_quotes_reg  <= in_quotes_next;
        end
    end

    csm_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .load_item (res),
        .ready     (stage_ready),
        .valid     (dst_valid),
        .item      (dst_item),
        .stall     (dst_stall)
    );

`ifndef SYNTHESIS
    a_empty_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_item.char_valid) |-> (dst_item.out_char == 8'h00))
        else $error("Result without a kept byte carries a nonzero byte.");

    a_plain_result_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && !dst_item.done_res) |-> dst_item.char_valid)
        else $error("Byte result without a kept byte.");

    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && src_item.end_of_input) |=>
        (!pend_valid_reg && !in_quotes_reg && !in_block_reg && (prev_byte_reg == 8'h00)))
        else $error("Text state not cleared after end item.");

    a_quotes_need_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_quotes_reg |-> pend_valid_reg)
        else $error("String flag set with no pending byte.");
`endif

endmodule

[sv/csm_settle.sv]
// Decision logic that keeps or drops the pending byte and updates the block and string flags.
`timescale 1ns / 1ps

module csm_settle
    import csm_pkg::*;
(
    input  csm_ctx_t     ctx,
    output csm_verdict_t verdict
);

    logic l_alpha;
    logic l_digit;
    logic l_quote;
    logic l_star;
    logic n_alpha;
    logic n_digit;
    logic n_quote;
    logic n_punct;
    logic n_colon;
    logic n_star;
    logic n_point;
    logic space_keep;

    assign l_alpha = is_alpha(ctx.prev_byte);
    assign l_digit = is_digit(ctx.prev_byte);
    assign l_quote = (ctx.prev_byte == CH_QUOTE);
    assign l_star  = (ctx.prev_byte == CH_STAR);

    // At the end of text the next byte belongs to no class at all.
    assign n_alpha = !ctx.next_none && is_alpha(ctx.next_byte);
    assign n_digit = !ctx.next_none && is_digit(ctx.next_byte);
    assign n_quote = !ctx.next_none && (ctx.next_byte == CH_QUOTE);
    assign n_punct = !ctx.next_none && is_punct(ctx.next_byte);
    assign n_colon = !ctx.next_none && (ctx.next_byte == CH_COLON);
    assign n_star  = !ctx.next_none && (ctx.next_byte == CH_STAR);
    assign n_point = !ctx.next_none && (ctx.next_byte == CH_POINT);

    assign space_keep = (l_alpha && (n_alpha || n_digit || n_quote)) ||
                        (l_quote && !n_punct) ||
                        (!ctx.in_block && n_colon) ||
                        l_digit || n_star || l_star;

    always_comb
    begin
        verdict.keep      = 1'b1;
        verdict.in_block  = ctx.in_block;
        verdict.in_quotes = ctx.in_quotes;
        if (ctx.in_quotes)
        begin
            if (ctx.pend_byte == CH_QUOTE)
            begin
                verdict.in_quotes = 1'b0;
            end
        end
        else
        begin
            case (ctx.pend_byte)
                CH_NEWLINE: verdict.keep = 1'b0;
                CH_LBRACE:  verdict.in_block = 1'b1;
                CH_RBRACE:  verdict.in_block = 1'b0;
                CH_QUOTE:   verdict.in_quotes = 1'b1;
                CH_ZERO:    verdict.keep = l_digit || !n_point;
                CH_SPACE:   verdict.keep = space_keep;
                default:    verdict.keep = 1'b1;
            endcase
        end
    end

endmodule

[sv/csm_out_stage.sv]
// Result register that holds one finished item and frees itself as soon as it is taken.
`timescale 1ns / 1ps

module csm_out_stage
    import csm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  csm_out_t load_item,
    output logic     ready,
    output logic     valid,
    output csm_out_t item,
    input  logic     stall
);

    logic     valid_reg;
    logic     valid_next;
    csm_out_t item_reg;

    assign ready      = !valid_reg || !stall;
    assign valid_next = load || (valid_reg && stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

[sim/css_stream_minifier_core_tb.sv]
// Self-checking testbench for the CSS stream minifier core with a byte-level predictor.
`timescale 1ns / 1ps

class minify_scoreboard;
    // Predictor copy of the text state.
    bit [7:0] held_byte;
    bit       held_ok;
    bit [7:0] last_byte;
    bit       block_open;
    bit       string_open;

    csm_pkg::csm_out_t want_q[$];
    int errors;
    int results;
    int kept_bytes;

    function new();
        clear_text();
        errors = 0;
        results = 0;
        kept_bytes = 0;
    endfunction

    function void clear_text();
        held_byte = 8'h00;
        held_ok = 1'b0;
        last_byte = 8'h00;
        block_open = 1'b0;
        string_open = 1'b0;
    endfunction

    // Classes take a 9-bit code so that "no next byte" (bit 8 set) falls in none of them.
    function bit letter(bit [8:0] c);
        return (c >= 9'h041 && c <= 9'h05A) || (c >= 9'h061 && c <= 9'h07A);
    endfunction

    function bit numeral(bit [8:0] c);
        return c >= 9'h030 && c <= 9'h039;
    endfunction

    function bit mark(bit [8:0] c);
        return (c >= 9'h021 && c <= 9'h02F) || (c >= 9'h03A && c <= 9'h040) ||
               (c >= 9'h05B && c <= 9'h060) || (c >= 9'h07B && c <= 9'h07E);
    endfunction

    // Decides whether the held byte survives, given the byte that follows it.
    function bit keep_held(bit [8:0] nx);
        bit       keep;
        bit [8:0] l;
        keep = 1'b1;
        l = {1'b0, last_byte};
        if (string_open)
        begin
            if (held_byte == csm_pkg::CH_QUOTE)
                string_open = 1'b0;
        end
        else if (held_byte == csm_pkg::CH_NEWLINE)
            keep = 1'b0;
        else if (held_byte == csm_pkg::CH_LBRACE)
            block_open = 1'b1;
        else if (held_byte == csm_pkg::CH_RBRACE)
            block_open = 1'b0;
        else if (held_byte == csm_pkg::CH_QUOTE)
            string_open = 1'b1;
        else if (held_byte == csm_pkg::CH_ZERO)
            keep = !(!numeral(l) && nx == {1'b0, csm_pkg::CH_POINT});
        else if (held_byte == csm_pkg::CH_SPACE)
            keep = (letter(l) && letter(nx)) ||
                   (letter(l) && numeral(nx)) ||
                   (letter(l) && nx == {1'b0, csm_pkg::CH_QUOTE}) ||
                   (l == {1'b0, csm_pkg::CH_QUOTE} && !mark(nx)) ||
                   (!block_open && nx == {1'b0, csm_pkg::CH_COLON}) ||
                   numeral(l) ||
                   nx == {1'b0, csm_pkg::CH_STAR} || l == {1'b0, csm_pkg::CH_STAR};
        last_byte = held_byte;
        return keep;
    endfunction

    function void note_input(csm_pkg::csm_in_t it);
        bit                kept;
        bit [7:0]          kb;
        bit [8:0]          nx;
        csm_pkg::csm_out_t r;
        kept = 1'b0;
        kb = 8'h00;
        if (held_ok)
        begin
            kb = held_byte;
            nx = it.end_of_input ? 9'h100 : {1'b0, it.in_char};
            kept = keep_held(nx);
        end
        if (it.end_of_input)
        begin
            r.out_char = kept ? kb : 8'h00;
            r.char_valid = kept;
            r.done_res = 1'b1;
            want_q.push_back(r);
            clear_text();
        end
        else
        begin
            held_byte = it.in_char;
            held_ok = 1'b1;
            if (kept)
            begin
                r.out_char = kb;
                r.char_valid = 1'b1;
                r.done_res = 1'b0;
                want_q.push_back(r);
            end
        end
    endfunction

    function void check_result(csm_pkg::csm_out_t got);
        csm_pkg::csm_out_t exp;
        results++;
        if (got.char_valid)
            kept_bytes++;
        if (want_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, got %h", $time, got);
            errors++;
            return;
        end
        exp = want_q.pop_front();
        if (got.out_char !== exp.out_char)
        begin
            $display("%0t: out_char expected %h got %h", $time, exp.out_char, got.out_char);
            errors++;
        end
        if (got.char_valid !== exp.char_valid)
        begin
            $display("%0t: char_valid expected %b got %b", $time, exp.char_valid,
                     got.char_valid);
            errors++;
        end
        if (got.done_res !== exp.done_res)
        begin
            $display("%0t: done_res expected %b got %b", $time, exp.done_res, got.done_res);
            errors++;
        end
    endfunction

    function int outstanding();
        return want_q.size();
    endfunction
endclass

module css_stream_minifier_core_tb;
    import csm_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int LONG_HOLD = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int END_MARK = 256;

    logic     clk;
    logic     rst_n;
    logic     src_valid;
    logic     src_stall;
    csm_in_t  src_item;
    logic     dst_valid;
    logic     dst_stall;
    csm_out_t dst_item;

    minify_scoreboard sb = new();

    bit send_quiet;
    bit take_quiet;
    bit hold_request;
    int items_sent;
    int texts_sent;

    css_stream_minifier_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .src_item(src_item),
        .dst_valid(dst_valid),
        .dst_stall(dst_stall),
        .dst_item(dst_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_valid && !src_stall)
                sb.note_input(src_item);
            if (dst_valid && !dst_stall)
                sb.check_result(dst_item);
        end
    end

    function automatic int draw_wait(bit quiet);
        if (quiet || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // Receiver: a random stall before each result, plus one long hold on request.
    initial
    begin
        int gap;
        bit hold_done;
        dst_stall <= 1'b1;
        take_quiet = 1'b0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                dst_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            if ($urandom_range(0, 39) == 0)
                take_quiet = !take_quiet;
            gap = draw_wait(take_quiet);
            if (gap > 0)
            begin
                dst_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            dst_stall <= 1'b0;
            do @(posedge clk); while (!dst_valid);
        end
    end

    task automatic send_item(input int code);
        int      gap;
        csm_in_t it;
        gap = draw_wait(send_quiet);
        it.in_char = code[7:0];
        it.end_of_input = code >= END_MARK;
        @(negedge clk);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_valid <= 1'b1;
        src_item <= it;
        do @(posedge clk); while (src_stall);
        items_sent++;
        if (it.end_of_input)
            texts_sent++;
    endtask

    // Mostly CSS-like bytes; noisy texts draw any byte value.
    function automatic int pick_byte(bit noisy);
        int r;
        if (noisy)
            return $urandom_range(0, 255);
        r = $urandom_range(0, 99);
        if (r < 22)
            return $urandom_range(0, 1) ? $urandom_range(8'h61, 8'h7A)
                                        : $urandom_range(8'h41, 8'h5A);
        if (r < 32)
            return $urandom_range(8'h30, 8'h39);
        if (r < 50)
            return CH_SPACE;
        if (r < 56)
            return CH_NEWLINE;
        if (r < 61)
            return CH_LBRACE;
        if (r < 66)
            return CH_RBRACE;
        if (r < 72)
            return CH_QUOTE;
        if (r < 79)
            return CH_ZERO;
        if (r < 85)
            return CH_POINT;
        if (r < 90)
            return CH_COLON;
        if (r < 94)
            return CH_STAR;
        return $urandom_range(8'h21, 8'h7E);
    endfunction

    task automatic send_text(input int len, input bit noisy);
        for (int i = 0; i < len; i++)
            send_item(pick_byte(noisy));
        send_item(END_MARK | $urandom_range(0, 255));
    endtask

    initial
    begin
        int seq[$];
        int start_items;
        rst_n = 1'b0;
        src_valid <= 1'b0;
        src_item <= '0;
        send_quiet = 1'b0;
        hold_request = 1'b0;
        items_sent = 0;
        texts_sent = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // NUL first byte, dropped zero before a point, spaces around letters, colon,
        // quotes and star, braces, newline, top byte, an empty text, a space kept after
        // a closing quote at the end, and an end that arrives inside a string.
        seq = '{8'h00, 8'h61, CH_SPACE, 8'h62, CH_SPACE, CH_ZERO, CH_POINT, 8'h35,
                CH_NEWLINE, CH_LBRACE, CH_SPACE, CH_COLON, CH_QUOTE, CH_SPACE, CH_QUOTE,
                CH_SPACE, CH_STAR, CH_RBRACE, 8'hFF, END_MARK | 8'hFF, END_MARK,
                CH_QUOTE, CH_QUOTE, CH_SPACE, END_MARK | 8'h5A,
                CH_QUOTE, 8'h78, END_MARK};
        foreach (seq[i])
            send_item(seq[i]);

        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                send_quiet = !send_quiet;
            // Partway through, the receiver holds off while items keep coming.
            if (texts_sent == 20)
            begin
                hold_request = 1'b1;
                send_quiet = 1'b1;
            end
            send_text($urandom_range(0, 40), $urandom_range(0, 9) == 0);
        end
        @(negedge clk);
        src_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d items in %0d texts, including a long receiver hold.",
                 items_sent, texts_sent);
        $display("Checked %0d results, %0d of them kept bytes.", sb.results, sb.kept_bytes);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
